FILE: design/asd_pkg.sv
// shared types, constants and a hex digit helper for the ais sentence decoder
`timescale 1ns / 1ps
package asd_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [2:0] FIELD_PAYLOAD = 3'd5;
  localparam logic [2:0] FIELD_FILL    = 3'd6;
  localparam logic [2:0] FIELDS_DONE   = 3'd7;

  localparam logic [27:0] LON_ABSENT   = 28'h6791AC0;
  localparam logic [26:0] LAT_ABSENT   = 27'h3412140;
  localparam logic [9:0]  SPEED_ABSENT = 10'd1023;
  localparam logic [8:0]  HEAD_ABSENT  = 9'd511;

  localparam logic [3:0] FILL_MAX = 4'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FRAMING  = 3'd1;
  localparam logic [2:0] ST_PAYLOAD  = 3'd2;
  localparam logic [2:0] ST_UNSUPP   = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;

  localparam logic [1:0] KIND_CLASS_A = 2'd0;
  localparam logic [1:0] KIND_BASE    = 2'd1;
  localparam logic [1:0] KIND_CLASS_B = 2'd2;
  localparam logic [1:0] KIND_ATON    = 2'd3;

  localparam logic [5:0] TYPE_POS1   = 6'd1;
  localparam logic [5:0] TYPE_POS2   = 6'd2;
  localparam logic [5:0] TYPE_POS3   = 6'd3;
  localparam logic [5:0] TYPE_BASE   = 6'd4;
  localparam logic [5:0] TYPE_CLASSB = 6'd18;
  localparam logic [5:0] TYPE_ATON   = 6'd21;
  localparam logic [5:0] TYPE_STATIC = 6'd24;

  typedef struct packed {
    logic       frame_ok;
    logic       pay_ok;
    logic [3:0] fill;
  } line_flags_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: design/asd_line.sv
// line splitter, framing and checksum tracking, payload character capture
`timescale 1ns / 1ps
module asd_line import asd_pkg::*; #(
  parameter int LINE_LIMIT    = 1024,
  parameter int PAYLOAD_LIMIT = 512,
  parameter int KEPT_CHARS    = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  output logic                             snap_valid,
  input  logic                             snap_take,
  output line_flags_t                      snap_flags,
  output logic [$clog2(PAYLOAD_LIMIT)-1:0] snap_plen,
  output logic [KEPT_CHARS-1:0][5:0]       snap_six,
  output logic [KEPT_CHARS-1:0]            snap_bad
);

  localparam int LW = $clog2(LINE_LIMIT);
  localparam int PW = $clog2(PAYLOAD_LIMIT);
  localparam int IW = $clog2(KEPT_CHARS);

  logic [LW-1:0] line_length, line_length_next;
  logic          content_ended, content_ended_next;
  logic          framing_error, framing_error_next;
  logic [7:0]    checksum_acc, checksum_acc_next;
  logic          star_seen, star_seen_next;
  logic [1:0]    after_star_count, after_star_count_next;
  logic [7:0]    expected_sum, expected_sum_next;
  logic [2:0]    field_index, field_index_next;
  logic [LW-1:0] field_length, field_length_next;
  logic [PW-1:0] payload_length, payload_length_next;
  logic [3:0]    fill_digit, fill_digit_next;
  logic          payload_error, payload_error_next;

  logic [KEPT_CHARS-1:0][5:0] payload_sixbits, six_upd;
  logic [KEPT_CHARS-1:0]      sixbit_invalid, bad_upd;

  logic          wr_en, wr_bad, finish, clear;
  logic [IW-1:0] wr_idx;
  logic [5:0]    wr_six;
  hex_t          hx;
  logic          accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = !snap_valid || snap_take;

  always_comb begin
    line_length_next      = line_length;
    content_ended_next    = content_ended;
    framing_error_next    = framing_error;
    checksum_acc_next     = checksum_acc;
    star_seen_next        = star_seen;
    after_star_count_next = after_star_count;
    expected_sum_next     = expected_sum;
    field_index_next      = field_index;
    field_length_next     = field_length;
    payload_length_next   = payload_length;
    fill_digit_next       = fill_digit;
    payload_error_next    = payload_error;
    wr_en  = 1'b0;
    wr_bad = 1'b0;
    wr_six = 6'd0;
    wr_idx = field_length[IW-1:0];
    finish = 1'b0;
    clear  = 1'b0;
    hx     = hex_of(in_byte);
    if (in_byte == CH_LF) begin
      finish = (line_length != '0);
      clear  = 1'b1;
    end else if (in_byte != CH_CR &&
                 ((LW+1)'(line_length) + (LW+1)'(1)) < (LW+1)'(LINE_LIMIT)) begin
      line_length_next = line_length + LW'(1);
      if (!content_ended) begin
        if (in_byte == CH_NUL) begin
          content_ended_next = 1'b1;
        end else begin
          if (line_length == '0 && in_byte != CH_BANG) framing_error_next = 1'b1;
          if (!star_seen) begin
            if (in_byte == CH_STAR) begin
              star_seen_next = 1'b1;
              if (line_length == LW'(1)) framing_error_next = 1'b1;
            end else if (line_length != '0) begin
              checksum_acc_next = checksum_acc ^ in_byte;
            end
            if (!payload_error && field_index != FIELDS_DONE) begin
              if (in_byte == CH_COMMA || in_byte == CH_STAR) begin
                if (field_index == FIELD_PAYLOAD) begin
                  if (field_length == '0 || int'(field_length) >= PAYLOAD_LIMIT) begin
                    payload_error_next = 1'b1;
                  end else begin
                    payload_length_next = PW'(field_length);
                  end
                  field_index_next = FIELD_FILL;
                end else if (field_index == FIELD_FILL) begin
                  if (field_length != LW'(1)) payload_error_next = 1'b1;
                  else field_index_next = FIELDS_DONE;
                end else begin
                  field_index_next = field_index + 3'd1;
                end
                field_length_next = '0;
              end else begin
                if (field_index == FIELD_PAYLOAD && int'(field_length) < KEPT_CHARS) begin
                  wr_en  = 1'b1;
                  wr_bad = !(in_byte >= 8'd48 && in_byte <= 8'd119);
                  if (!wr_bad) begin
                    wr_six = (in_byte <= 8'd88) ? 6'(in_byte - 8'd48) : 6'(in_byte - 8'd56);
                  end
                end
                if (field_index == FIELD_FILL && field_length == '0) begin
                  if (in_byte >= 8'h30 && in_byte <= 8'h39) fill_digit_next = 4'(in_byte - 8'h30);
                  else payload_error_next = 1'b1;
                end
                field_length_next = field_length + LW'(1);
              end
            end
          end else if (after_star_count < 2'd2) begin
            if (!hx.ok) framing_error_next = 1'b1;
            else expected_sum_next = {expected_sum[3:0], hx.val};
            after_star_count_next = after_star_count + 2'd1;
          end else begin
            framing_error_next = 1'b1;
          end
        end
      end
    end
    if (in_byte != CH_LF && in_last) begin
      finish = (line_length_next != '0);
      clear  = 1'b1;
    end
  end

  always_comb begin
    six_upd = payload_sixbits;
    bad_upd = sixbit_invalid;
    if (wr_en) begin
      six_upd[wr_idx] = wr_six;
      bad_upd[wr_idx] = wr_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      payload_sixbits <= six_upd;
      sixbit_invalid  <= bad_upd;
    end
    if (accept && finish) begin
      snap_flags.frame_ok <= !framing_error_next && star_seen_next &&
                             after_star_count_next == 2'd2 &&
                             checksum_acc_next == expected_sum_next;
      snap_flags.pay_ok   <= !payload_error_next && field_index_next == FIELDS_DONE;
      snap_flags.fill     <= fill_digit_next;
      snap_plen           <= payload_length_next;
      snap_six            <= six_upd;
      snap_bad            <= bad_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid       <= 1'b0;
      line_length      <= '0;
      content_ended    <= 1'b0;
      framing_error    <= 1'b0;
      checksum_acc     <= '0;
      star_seen        <= 1'b0;
      after_star_count <= '0;
      expected_sum     <= '0;
      field_index      <= '0;
      field_length     <= '0;
      payload_length   <= '0;
      fill_digit       <= '0;
      payload_error    <= 1'b0;
    end else begin
      if (accept && finish) snap_valid <= 1'b1;
      else if (snap_take) snap_valid <= 1'b0;
      if (accept) begin
        if (clear) begin
          line_length      <= '0;
          content_ended    <= 1'b0;
          framing_error    <= 1'b0;
          checksum_acc     <= '0;
          star_seen        <= 1'b0;
          after_star_count <= '0;
          expected_sum     <= '0;
          field_index      <= '0;
          field_length     <= '0;
          payload_length   <= '0;
          fill_digit       <= '0;
          payload_error    <= 1'b0;
        end else begin
          line_length      <= line_length_next;
          content_ended    <= content_ended_next;
          framing_error    <= framing_error_next;
          checksum_acc     <= checksum_acc_next;
          star_seen        <= star_seen_next;
          after_star_count <= after_star_count_next;
          expected_sum     <= expected_sum_next;
          field_index      <= field_index_next;
          field_length     <= field_length_next;
          payload_length   <= payload_length_next;
          fill_digit       <= fill_digit_next;
          payload_error    <= payload_error_next;
        end
      end
    end
  end

endmodule

FILE: design/asd_decode.sv
// message decode of a finished line and the result register
`timescale 1ns / 1ps
module asd_decode import asd_pkg::*; #(
  parameter int PAYLOAD_LIMIT = 512,
  parameter int KEPT_CHARS    = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             snap_valid,
  output logic                             snap_take,
  input  line_flags_t                      snap_flags,
  input  logic [$clog2(PAYLOAD_LIMIT)-1:0] snap_plen,
  input  logic [KEPT_CHARS-1:0][5:0]       snap_six,
  input  logic [KEPT_CHARS-1:0]            snap_bad,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       status,
  output logic [5:0]                       msg_type,
  output logic [29:0]                      mmsi,
  output logic [1:0]                       sender_kind,
  output logic                             has_speed,
  output logic [9:0]                       speed_raw,
  output logic                             has_location,
  output logic [27:0]                      longitude_raw,
  output logic [26:0]                      latitude_raw,
  output logic                             has_heading,
  output logic [8:0]                       heading_deg
);

  localparam int PW = $clog2(PAYLOAD_LIMIT);
  localparam int AW = PW + 3;

  function automatic logic [29:0] rd(input logic [KEPT_CHARS-1:0][5:0] sx,
                                     input logic [KEPT_CHARS-1:0] bad,
                                     input int start, input int n);
    logic [29:0] v;
    logic        ok;
    int          p;
    v  = '0;
    ok = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i < n) begin
        p = start + i;
        if (p / 6 >= KEPT_CHARS) begin
          ok = 1'b0;
        end else begin
          if (bad[p / 6]) ok = 1'b0;
          v = {v[28:0], sx[p / 6][5 - (p % 6)]};
        end
      end
    end
    return ok ? v : 30'd0;
  endfunction

  logic [AW-1:0] avail, need;
  logic [5:0]    ty;
  logic          known;
  logic [1:0]    kind;
  logic [9:0]    sp;
  logic [27:0]   lon;
  logic [26:0]   lat;
  logic [8:0]    hd;

  logic [2:0]  r_status;
  logic [5:0]  r_type;
  logic [29:0] r_mmsi;
  logic [1:0]  r_kind;
  logic        r_hs, r_hl, r_hh;
  logic [9:0]  r_sp;
  logic [27:0] r_lon;
  logic [26:0] r_lat;
  logic [8:0]  r_hd;

  assign snap_take = snap_valid && (!out_valid || out_ready);

  always_comb begin
    avail = (AW'(snap_plen) << 2) + (AW'(snap_plen) << 1) - AW'(snap_flags.fill);
    ty    = 6'(rd(snap_six, snap_bad, 0, 6));
    known = 1'b1;
    need  = AW'(137);
    kind  = KIND_CLASS_A;
    sp    = SPEED_ABSENT;
    lon   = LON_ABSENT;
    lat   = LAT_ABSENT;
    hd    = HEAD_ABSENT;
    case (ty)
      TYPE_POS1, TYPE_POS2, TYPE_POS3: begin
        need = AW'(137);
        kind = KIND_CLASS_A;
        sp   = 10'(rd(snap_six, snap_bad, 50, 10));
        lon  = 28'(rd(snap_six, snap_bad, 61, 28));
        lat  = 27'(rd(snap_six, snap_bad, 89, 27));
        hd   = 9'(rd(snap_six, snap_bad, 128, 9));
      end
      TYPE_BASE: begin
        need = AW'(135);
        kind = KIND_BASE;
        lon  = 28'(rd(snap_six, snap_bad, 79, 28));
        lat  = 27'(rd(snap_six, snap_bad, 108, 27));
      end
      TYPE_CLASSB: begin
        need = AW'(133);
        kind = KIND_CLASS_B;
        sp   = 10'(rd(snap_six, snap_bad, 46, 10));
        lon  = 28'(rd(snap_six, snap_bad, 57, 28));
        lat  = 27'(rd(snap_six, snap_bad, 85, 27));
        hd   = 9'(rd(snap_six, snap_bad, 124, 9));
      end
      TYPE_ATON: begin
        need = AW'(219);
        kind = KIND_ATON;
        lon  = 28'(rd(snap_six, snap_bad, 164, 28));
        lat  = 27'(rd(snap_six, snap_bad, 192, 27));
      end
      TYPE_STATIC: begin
        need = AW'(40);
        kind = KIND_CLASS_B;
      end
      default: known = 1'b0;
    endcase

    r_status = ST_OK;
    r_type   = '0;
    r_mmsi   = '0;
    r_kind   = '0;
    r_hs     = 1'b0;
    r_sp     = '0;
    r_hl     = 1'b0;
    r_lon    = '0;
    r_lat    = '0;
    r_hh     = 1'b0;
    r_hd     = '0;
    if (!snap_flags.frame_ok) begin
      r_status = ST_FRAMING;
    end else if (!snap_flags.pay_ok) begin
      r_status = ST_PAYLOAD;
    end else if (snap_flags.fill > FILL_MAX || avail < AW'(38) || !known) begin
      r_status = ST_UNSUPP;
    end else begin
      r_type = ty;
      r_mmsi = rd(snap_six, snap_bad, 8, 30);
      if (avail < need) begin
        r_status = ST_SHORT;
      end else begin
        r_kind = kind;
        if (sp != SPEED_ABSENT) begin
          r_hs = 1'b1;
          r_sp = sp;
        end
        if (lon != LON_ABSENT && lat != LAT_ABSENT) begin
          r_hl  = 1'b1;
          r_lon = lon;
          r_lat = lat;
        end
        if (hd != HEAD_ABSENT) begin
          r_hh = 1'b1;
          r_hd = hd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      status        <= r_status;
      msg_type      <= r_type;
      mmsi          <= r_mmsi;
      sender_kind   <= r_kind;
      has_speed     <= r_hs;
      speed_raw     <= r_sp;
      has_location  <= r_hl;
      longitude_raw <= r_lon;
      latitude_raw  <= r_lat;
      has_heading   <= r_hh;
      heading_deg   <= r_hd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= snap_valid;
    end
  end

endmodule

FILE: design/ais_sentence_decoder.sv
// top level of the ais sentence decoder
`timescale 1ns / 1ps
// Takes one datagram byte per cycle on the s side (tlast marks the datagram's last byte) and
// gives one decoded record on the m side for each nonempty line. The line tracker updates its
// state as each byte arrives, a finished line is latched into a snapshot register, and the
// snapshot is then decoded into the result register once that register is free or being read.
// Input stalls only while both the snapshot and the result register are full and the m side is
// not taking words.
module ais_sentence_decoder import asd_pkg::*; #(
  parameter int LINE_LIMIT    = 1024,
  parameter int PAYLOAD_LIMIT = 512,
  parameter int KEPT_CHARS    = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // datagram_end
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, msg_type, mmsi, sender_kind, has_speed, speed_raw, has_location,
  // longitude_raw, latitude_raw, has_heading, heading_deg, zero pad
  output logic [119:0] m_tdata
);

  logic                             snap_valid, snap_take;
  line_flags_t                      snap_flags;
  logic [$clog2(PAYLOAD_LIMIT)-1:0] snap_plen;
  logic [KEPT_CHARS-1:0][5:0]       snap_six;
  logic [KEPT_CHARS-1:0]            snap_bad;

  logic [2:0]  status;
  logic [5:0]  msg_type;
  logic [29:0] mmsi;
  logic [1:0]  sender_kind;
  logic        has_speed, has_location, has_heading;
  logic [9:0]  speed_raw;
  logic [27:0] longitude_raw;
  logic [26:0] latitude_raw;
  logic [8:0]  heading_deg;

  asd_line #(
    .LINE_LIMIT(LINE_LIMIT), .PAYLOAD_LIMIT(PAYLOAD_LIMIT), .KEPT_CHARS(KEPT_CHARS)
  ) u_line (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata), .in_last(s_tlast),
    .snap_valid(snap_valid), .snap_take(snap_take), .snap_flags(snap_flags),
    .snap_plen(snap_plen), .snap_six(snap_six), .snap_bad(snap_bad)
  );

  asd_decode #(
    .PAYLOAD_LIMIT(PAYLOAD_LIMIT), .KEPT_CHARS(KEPT_CHARS)
  ) u_decode (
    .clk(clk), .rst(rst),
    .snap_valid(snap_valid), .snap_take(snap_take), .snap_flags(snap_flags),
    .snap_plen(snap_plen), .snap_six(snap_six), .snap_bad(snap_bad),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .status(status), .msg_type(msg_type), .mmsi(mmsi), .sender_kind(sender_kind),
    .has_speed(has_speed), .speed_raw(speed_raw), .has_location(has_location),
    .longitude_raw(longitude_raw), .latitude_raw(latitude_raw),
    .has_heading(has_heading), .heading_deg(heading_deg)
  );

  assign m_tdata = {2'b00, heading_deg, has_heading, latitude_raw, longitude_raw,
                    has_location, speed_raw, has_speed, sender_kind, mmsi, msg_type, status};

endmodule
